[rtl/pixel_gradient_energy_map_defines.svh]
// Assertion helpers for the gradient energy block.
// Each one samples on the rising edge of clk and is off while arst_n is low.
`ifndef PIXEL_GRADIENT_ENERGY_MAP_DEFINES_SVH
`define PIXEL_GRADIENT_ENERGY_MAP_DEFINES_SVH

// Condition must hold on the same edge as the trigger.
`define PGE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold on the edge after the trigger.
`define PGE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pge_pkg.sv]
`timescale 1ns / 1ps

package pge_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int PIXEL_BITS  = 8;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WIDTH_REG_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W       = 16;
	localparam int ENERGY_W    = PIXEL_BITS + 2;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_IDX_W  = PADDR_W - 2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_IMAGE_WIDTH  = reg_idx_t'(0);
	localparam reg_idx_t REG_IMAGE_HEIGHT = reg_idx_t'(1);

	localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET  = WIDTH_REG_W'(1024);
	localparam logic [ROW_W-1:0]       IMAGE_HEIGHT_RESET = ROW_W'(768);

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COL_W-1:0]      col_t;
	typedef logic [ROW_W-1:0]      row_t;
	typedef logic [ENERGY_W-1:0]   energy_t;

	// One classified pixel, handed from the front end to the back end.
	typedef struct packed {
		pixel_t pix;
		col_t   col;
		row_t   row;
		logic   row_ge1;
		logic   row_ge2;
		logic   col_ge1;
		logic   col_ge2;
		logic   last_row;
		logic   final_col;
	} item_t;

	typedef struct packed {
		energy_t energy;
		row_t    row;
		col_t    col;
		logic    last_of_run;
		logic    frame_done;
	} result_t;

endpackage

[rtl/pixel_gradient_energy_map.sv]
`timescale 1ns / 1ps
// Gradient energy map for greyscale frames (four-neighbor L1 energy, as used in seam
// carving). Push pixels in raster order; each result beat gives one pixel's energy
// |p-left| + |p-right| + |p-up| + |p-down| with its row and column, a neighbor off the
// frame edge counting as the pixel itself. The energy of row y comes out while row y+1
// goes in; on the frame's last row that row's own energies come out too, so one pixel
// yields zero (first row), one, or up to three results, in the order: pixel above, this
// row's previous pixel, this row's final pixel. last_of_run marks the final result of
// each pixel, frame_done the energy of the frame's final pixel. Rate: one pixel per
// clock sustained while results are popped, set by the line stores, which take one read
// set and one write per clock; results leave at one beat per clock, so on the last row
// the result port paces the input. A pixel's results pass the item queue, the back-end
// stages and the result queue on their way out. Line stores are three 1024x8
// memories (the newer row held twice for a third read port); they are not cleared at
// reset and there is no clearing pass. Registers: image_width at 0x0 (11 bits, used as
// 1..1024), image_height at 0x4 (16 bits, 0 is used as 1). Pixels already pushed keep
// the geometry seen when they were accepted, so the registers may be written whenever
// no results are outstanding; counters are kept.
module pixel_gradient_energy_map #(
	parameter int ITEM_QUEUE_DEPTH   = 4,
	parameter int RESULT_QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pge_pkg::PADDR_W-1:0]      paddr,
	input  logic [pge_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pge_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// pixel input
	input  logic                             push,
	output logic                             full,
	input  logic [pge_pkg::PIXEL_BITS-1:0]   pixel_value,
	// result output
	output logic                             empty,
	input  logic                             pop,
	output logic [pge_pkg::ENERGY_W-1:0]     energy_value,
	output logic [pge_pkg::ROW_W-1:0]        row_index,
	output logic [pge_pkg::COL_W-1:0]        column_index,
	output logic                             last_of_run,
	output logic                             frame_done
);

	import pge_pkg::*;

	logic    iq_push;
	logic    iq_full;
	item_t   iq_wr_item;
	logic    iq_pop;
	logic    iq_empty;
	item_t   iq_head;
	logic    rq_push;
	logic    rq_full;
	result_t rq_wr_data;
	result_t rq_head;

	// every access completes in its first access cycle
	assign pready = 1'b1;
	assign full   = iq_full;

	// front end: registers, raster position, edge classification
	pge_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.push        (push),
		.pixel_value (pixel_value),
		.queue_full  (iq_full),
		.queue_push  (iq_push),
		.queue_item  (iq_wr_item)
	);

	// decouple classification from the store pipeline so each side can stall alone
	pge_fifo #(
		.DW    ($bits(item_t)),
		.DEPTH (ITEM_QUEUE_DEPTH)
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (iq_push),
		.wr_data (iq_wr_item),
		.full    (iq_full),
		.rd_en   (iq_pop),
		.rd_data (iq_head),
		.empty   (iq_empty)
	);

	// back end: line stores, neighbor selection, energy sums, result sequencing
	pge_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (!iq_empty),
		.queue_item  (iq_head),
		.queue_pop   (iq_pop),
		.result_full (rq_full),
		.result_push (rq_push),
		.result_data (rq_wr_data)
	);

	// hold finished results until popped; head entry drives the result ports
	pge_fifo #(
		.DW    ($bits(result_t)),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wr_data),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_head),
		.empty   (empty)
	);

	assign energy_value = rq_head.energy;
	assign row_index    = rq_head.row;
	assign column_index = rq_head.col;
	assign last_of_run  = rq_head.last_of_run;
	assign frame_done   = rq_head.frame_done;

endmodule

[rtl/pge_fifo.sv]
`timescale 1ns / 1ps

module pge_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [DW-1:0] wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic [DW-1:0] rd_data,
	output logic          empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DW-1:0]    slots_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = slots_q[head_q];

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			slots_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_fire) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
			end
			if (rd_fire) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/pge_front.sv]
`timescale 1ns / 1ps

module pge_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pge_pkg::PADDR_W-1:0]      paddr,
	input  logic [pge_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pge_pkg::APB_DATA_W-1:0]   prdata,
	input  logic                             push,
	input  logic [pge_pkg::PIXEL_BITS-1:0]   pixel_value,
	input  logic                             queue_full,
	output logic                             queue_push,
	output pge_pkg::item_t                   queue_item
);

	import pge_pkg::*;

	logic [WIDTH_REG_W-1:0] width_q;
	row_t                   height_q;
	col_t                   col_q;
	row_t                   row_q;

	reg_idx_t               cfg_idx;
	logic                   cfg_write;
	logic [WIDTH_REG_W-1:0] width_eff;
	logic [ROW_W:0]         height_eff;
	logic [ROW_W:0]         row_next;
	col_t                   col_eff;
	logic [WIDTH_REG_W-1:0] col_plus1;
	logic                   last_row;
	logic                   final_col;

	assign cfg_idx   = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		if (width_q == '0) begin
			width_eff = WIDTH_REG_W'(1);
		end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
			width_eff = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
	end

	assign height_eff = (height_q == '0) ? (ROW_W + 1)'(1) : {1'b0, height_q};

	// a column at or past the width counts as the final column of the row
	assign col_eff   = (WIDTH_REG_W'(col_q) >= width_eff) ? COL_W'(width_eff - WIDTH_REG_W'(1))
	                                                       : col_q;
	assign col_plus1 = WIDTH_REG_W'(col_eff) + WIDTH_REG_W'(1);
	assign final_col = (col_plus1 == width_eff);
	assign row_next  = {1'b0, row_q} + (ROW_W + 1)'(1);
	assign last_row  = (row_next >= height_eff);

	assign queue_push = push && !queue_full;

	always_comb begin
		queue_item.pix       = pixel_value;
		queue_item.col       = col_eff;
		queue_item.row       = row_q;
		queue_item.row_ge1   = (row_q != '0);
		queue_item.row_ge2   = (row_q[ROW_W-1:1] != '0);
		queue_item.col_ge1   = (col_eff != '0);
		queue_item.col_ge2   = (col_eff[COL_W-1:1] != '0);
		queue_item.last_row  = last_row;
		queue_item.final_col = final_col;
	end

	always_comb begin
		case (cfg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RESET;
			height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the raster position; wrap to a new frame after the last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (queue_push) begin
			if (final_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_plus1[COL_W-1:0];
			end
		end
	end

endmodule

[rtl/pge_back.sv]
`timescale 1ns / 1ps
`include "pixel_gradient_energy_map_defines.svh"

module pge_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_valid,
	input  pge_pkg::item_t    queue_item,
	output logic              queue_pop,
	input  logic              result_full,
	output logic              result_push,
	output pge_pkg::result_t  result_data
);

	import pge_pkg::*;

	// result slots of one pixel, in delivery order
	localparam int RES_ABOVE = 0;
	localparam int RES_LEFT  = 1;
	localparam int RES_EDGE  = 2;

	function automatic pixel_t abs_diff(input pixel_t a, input pixel_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// line stores; the newer row is kept twice for a third read port
	pixel_t newer_a_mem [MAX_WIDTH];
	pixel_t newer_b_mem [MAX_WIDTH];
	pixel_t older_mem   [MAX_WIDTH];

	logic   take;
	logic   rdy_s1;
	logic   adv_s1;
	logic   rdy_s2;
	logic   adv_s2;
	logic   rdy_s3;
	logic   done_s3;
	logic   wr_newer;
	logic   wr_older;
	col_t   addr_right;
	col_t   addr_upl;
	col_t   addr_left2;

	logic   valid_s1;
	item_t  item_s1;
	pixel_t mid_s1;
	pixel_t right_s1;
	pixel_t up_s1;
	pixel_t upl_s1;
	pixel_t left2_s1;
	pixel_t prior_a_q;
	pixel_t prior_b_q;

	pixel_t a_left;
	pixel_t a_right;
	pixel_t a_up;
	pixel_t b_left;
	pixel_t b_up;
	pixel_t c_left;
	pixel_t c_up;
	logic [2:0] mask_next;

	logic       valid_s2;
	logic [2:0] mask_s2;
	row_t       row_s2;
	col_t       col_s2;
	pixel_t     da_l_s2;
	pixel_t     da_r_s2;
	pixel_t     da_u_s2;
	pixel_t     da_d_s2;
	pixel_t     db_l_s2;
	pixel_t     db_r_s2;
	pixel_t     db_u_s2;
	pixel_t     dc_l_s2;
	pixel_t     dc_u_s2;

	logic       valid_s3;
	logic [2:0] pend_s3;
	row_t       row_s3;
	col_t       col_s3;
	energy_t    ea_s3;
	energy_t    eb_s3;
	energy_t    ec_s3;
	logic [2:0] sel;
	logic [2:0] rest;

	// handshake between stages
	assign adv_s1    = valid_s1 && rdy_s2;
	assign rdy_s1    = !valid_s1 || adv_s1;
	assign take      = queue_valid && rdy_s1;
	assign queue_pop = take;
	assign adv_s2    = valid_s2 && rdy_s3;
	assign rdy_s2    = !valid_s2 || adv_s2;
	assign rdy_s3    = !valid_s3 || done_s3;

	// the pixel leaving stage one writes the stores on the edge the next one reads
	assign wr_newer   = adv_s1;
	assign wr_older   = adv_s1 && item_s1.row_ge1;
	assign addr_right = queue_item.col + col_t'(1);
	assign addr_upl   = queue_item.col - col_t'(1);
	assign addr_left2 = queue_item.col - col_t'(2);

	always_ff @(posedge clk) begin
		if (wr_newer) begin
			newer_a_mem[item_s1.col] <= item_s1.pix;
		end
		if (take) begin
			mid_s1   <= (wr_newer && item_s1.col == queue_item.col) ? item_s1.pix
			                                                      : newer_a_mem[queue_item.col];
			right_s1 <= (wr_newer && item_s1.col == addr_right) ? item_s1.pix
			                                                    : newer_a_mem[addr_right];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_newer) begin
			newer_b_mem[item_s1.col] <= item_s1.pix;
		end
		if (take) begin
			left2_s1 <= (wr_newer && item_s1.col == addr_left2) ? item_s1.pix
			                                                    : newer_b_mem[addr_left2];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_older) begin
			older_mem[item_s1.col] <= mid_s1;
		end
		if (take) begin
			up_s1  <= (wr_older && item_s1.col == queue_item.col) ? mid_s1
			                                                    : older_mem[queue_item.col];
			upl_s1 <= (wr_older && item_s1.col == addr_upl) ? mid_s1 : older_mem[addr_upl];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= queue_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			prior_a_q <= '0;
			prior_b_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				prior_b_q <= item_s1.pix;
				if (item_s1.row_ge1) begin
					prior_a_q <= mid_s1;
				end
			end
		end
	end

	// pick neighbors; an edge neighbor falls back to the pixel itself
	assign a_left  = item_s1.col_ge1   ? prior_a_q : mid_s1;
	assign a_right = item_s1.final_col ? mid_s1    : right_s1;
	assign a_up    = item_s1.row_ge2   ? up_s1     : mid_s1;
	assign b_left  = item_s1.col_ge2   ? left2_s1  : prior_b_q;
	assign b_up    = item_s1.row_ge1   ? upl_s1    : prior_b_q;
	assign c_left  = item_s1.col_ge1   ? prior_b_q : item_s1.pix;
	assign c_up    = item_s1.row_ge1   ? mid_s1    : item_s1.pix;

	always_comb begin
		mask_next            = '0;
		mask_next[RES_ABOVE] = item_s1.row_ge1;
		mask_next[RES_LEFT]  = item_s1.last_row && item_s1.col_ge1;
		mask_next[RES_EDGE]  = item_s1.last_row && item_s1.final_col;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mask_s2 <= mask_next;
			row_s2  <= item_s1.row;
			col_s2  <= item_s1.col;
			da_l_s2 <= abs_diff(mid_s1, a_left);
			da_r_s2 <= abs_diff(mid_s1, a_right);
			da_u_s2 <= abs_diff(mid_s1, a_up);
			da_d_s2 <= abs_diff(mid_s1, item_s1.pix);
			db_l_s2 <= abs_diff(prior_b_q, b_left);
			db_r_s2 <= abs_diff(prior_b_q, item_s1.pix);
			db_u_s2 <= abs_diff(prior_b_q, b_up);
			dc_l_s2 <= abs_diff(item_s1.pix, c_left);
			dc_u_s2 <= abs_diff(item_s1.pix, c_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			ea_s3  <= ENERGY_W'(da_l_s2) + ENERGY_W'(da_r_s2)
			        + ENERGY_W'(da_u_s2) + ENERGY_W'(da_d_s2);
			eb_s3  <= ENERGY_W'(db_l_s2) + ENERGY_W'(db_r_s2) + ENERGY_W'(db_u_s2);
			ec_s3  <= ENERGY_W'(dc_l_s2) + ENERGY_W'(dc_u_s2);
		end
	end

	// drain pending results one beat at a time, oldest slot first
	always_comb begin
		sel = '0;
		if (pend_s3[RES_ABOVE]) begin
			sel[RES_ABOVE] = 1'b1;
		end else if (pend_s3[RES_LEFT]) begin
			sel[RES_LEFT] = 1'b1;
		end else if (pend_s3[RES_EDGE]) begin
			sel[RES_EDGE] = 1'b1;
		end
	end

	assign rest        = pend_s3 & ~sel;
	assign result_push = valid_s3 && (pend_s3 != '0) && !result_full;
	assign done_s3     = valid_s3 && ((pend_s3 == '0) || (result_push && rest == '0));

	always_comb begin
		result_data.energy      = sel[RES_ABOVE] ? ea_s3 : (sel[RES_LEFT] ? eb_s3 : ec_s3);
		result_data.row         = sel[RES_ABOVE] ? row_s3 - row_t'(1) : row_s3;
		result_data.col         = sel[RES_LEFT] ? col_s3 - col_t'(1) : col_s3;
		result_data.last_of_run = (rest == '0);
		result_data.frame_done  = sel[RES_EDGE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			pend_s3  <= '0;
		end else if (adv_s2) begin
			valid_s3 <= 1'b1;
			pend_s3  <= mask_s2;
		end else if (done_s3) begin
			valid_s3 <= 1'b0;
			pend_s3  <= '0;
		end else if (result_push) begin
			pend_s3 <= rest;
		end
	end

	`PGE_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1 && $stable(item_s1) && $stable(mid_s1), "stage one changed while stalled")
	`PGE_ASSERT_IMPLIES(a_sel_onehot, result_push, $onehot(sel), "result beat without a single slot")
	`PGE_ASSERT_IMPLIES(a_done_last, result_push && result_data.frame_done, result_data.last_of_run, "frame end not last of run")
	`PGE_ASSERT_IMPLIES(a_above_row, result_push && sel[RES_ABOVE], row_s3 != '0, "above result on row zero")
	`PGE_ASSERT_IMPLIES(a_idle_clear, !valid_s3, pend_s3 == '0, "pending results in empty stage")

endmodule

[dv/pixel_gradient_energy_map_test.sv]
`timescale 1ns / 1ps

module pixel_gradient_energy_map_test;

	import pge_pkg::*;

	// Tracks the block's geometry, line stores and raster position, and keeps
	// the energy beats that the accepted pixels are due to produce, oldest first.
	class energy_scoreboard;
		logic [10:0]  width_reg;
		logic [15:0]  height_reg;
		pixel_t       two_back [MAX_WIDTH];
		pixel_t       one_back [MAX_WIDTH];
		pixel_t       diag_left;
		pixel_t       run_left;
		int unsigned  col_pos;
		int unsigned  row_pos;
		result_t      awaited [$];
		int unsigned  mismatches;

		function new();
			width_reg  = IMAGE_WIDTH_RESET;
			height_reg = IMAGE_HEIGHT_RESET;
			diag_left  = '0;
			run_left   = '0;
			col_pos    = 0;
			row_pos    = 0;
			mismatches = 0;
			foreach (two_back[i]) begin
				two_back[i] = '0;
				one_back[i] = '0;
			end
		endfunction

		function void set_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			if (idx == REG_IMAGE_WIDTH) width_reg = value[10:0];
			else if (idx == REG_IMAGE_HEIGHT) height_reg = value[15:0];
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function int unsigned gap_of(int unsigned a, int unsigned b);
			return (a > b) ? a - b : b - a;
		endfunction

		function int unsigned l1_energy(int unsigned p, int unsigned lf, int unsigned rt,
				int unsigned up, int unsigned dn);
			return gap_of(p, lf) + gap_of(p, rt) + gap_of(p, up) + gap_of(p, dn);
		endfunction

		function result_t beat_of(int unsigned e, int unsigned r, int unsigned c, logic done);
			result_t b;
			b.energy      = energy_t'(e);
			b.row         = row_t'(r);
			b.col         = col_t'(c);
			b.last_of_run = 1'b0;
			b.frame_done  = done;
			return b;
		endfunction

		// Advance the raster by one accepted pixel and queue the beats it causes.
		function void note_pixel(pixel_t px);
			int unsigned w, h, c, r, mid, up, lf, rt, n;
			logic        last_row;
			result_t     run [3];
			w = width_reg;
			if (w < 1) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			h = (height_reg == 0) ? 1 : height_reg;
			c = (col_pos >= w) ? w - 1 : col_pos;
			r = row_pos;
			last_row = (r + 1 >= h);
			n = 0;
			if (r >= 1) begin
				mid = one_back[c];
				up  = (r >= 2) ? two_back[c] : mid;
				lf  = (c == 0) ? mid : diag_left;
				rt  = (c + 1 < w) ? one_back[c + 1] : mid;
				run[n] = beat_of(l1_energy(mid, lf, rt, up, px), r - 1, c, 1'b0);
				n++;
				two_back[c] = pixel_t'(mid);
				diag_left   = pixel_t'(mid);
			end
			one_back[c] = px;
			if (last_row) begin
				if (c >= 1) begin
					mid = run_left;
					lf  = (c >= 2) ? one_back[c - 2] : mid;
					up  = (r >= 1) ? two_back[c - 1] : mid;
					run[n] = beat_of(l1_energy(mid, lf, px, up, mid), r, c - 1, 1'b0);
					n++;
				end
				if (c + 1 == w) begin
					lf = (c >= 1) ? run_left : px;
					up = (r >= 1) ? two_back[c] : px;
					run[n] = beat_of(l1_energy(px, lf, px, up, px), r, c, 1'b1);
					n++;
				end
			end
			run_left = px;
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
			end else begin
				col_pos = c + 1;
			end
			if (n > 0) run[n - 1].last_of_run = 1'b1;
			for (int i = 0; i < n; i++) awaited = {awaited, run[i]};
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected energy beat: e=%0d row=%0d col=%0d last=%b done=%b",
						got.energy, got.row, got.col, got.last_of_run, got.frame_done);
				return;
			end
			want = awaited.pop_front();
			if (got.energy !== want.energy || got.row !== want.row || got.col !== want.col ||
					got.last_of_run !== want.last_of_run ||
					got.frame_done !== want.frame_done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("energy beat mismatch: want e=%0d row=%0d col=%0d last=%b done=%b, %s",
						want.energy, want.row, want.col, want.last_of_run, want.frame_done,
						$sformatf("got e=%0d row=%0d col=%0d last=%b done=%b", got.energy,
							got.row, got.col, got.last_of_run, got.frame_done));
			end
		endfunction
	endclass

	typedef enum {PIX_RANDOM, PIX_CHECKER} pixel_style_t;

	localparam int unsigned HOLD_AT_BEAT = 40;   // beat inside the pressure frame that starts the hold
	localparam int unsigned LONG_HOLD    = 400;  // cycles the result side holds off
	localparam int unsigned SETTLE       = 8;    // cycles waited after the expected beats have drained

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [PADDR_W-1:0]    paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push    = 1'b0;
	logic                  full;
	pixel_t                pixel_value = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	energy_t               energy_value;
	row_t                  row_index;
	col_t                  column_index;
	logic                  last_of_run;
	logic                  frame_done;

	energy_scoreboard sb;
	bit               steady_in;
	bit               steady_out;

	pixel_gradient_energy_map dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.pixel_value  (pixel_value),
		.empty        (empty),
		.pop          (pop),
		.energy_value (energy_value),
		.row_index    (row_index),
		.column_index (column_index),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length between beats: mostly none, sometimes short, rarely a long gap.
	function automatic int unsigned next_gap(input bit steady);
		int unsigned roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Setup cycle, then access cycle; the register takes the value at the edge
	// where the access completes, so update the shadow copy right there.
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer pixels one beat at a time; a beat lands at the edge where full is low.
	task automatic push_pixels(input int unsigned count, input pixel_style_t style);
		int unsigned gap;
		pixel_t      v;
		for (int unsigned k = 0; k < count; k++) begin
			gap = next_gap(steady_in);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (style == PIX_CHECKER) v = (k % 2) ? 8'hFF : 8'h00;
			else if ($urandom_range(0, 4) == 0) v = {8{1'($urandom_range(0, 1))}};
			else v = pixel_t'($urandom);
			push        <= 1'b1;
			pixel_value <= v;
			do @(posedge clk); while (full);
			sb.note_pixel(v);
		end
		push <= 1'b0;
	endtask

	// Let every expected beat drain, then give first-row pixels time to clear the pipe.
	task automatic settle();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Let the pipe settle, write both registers, then push the given number of pixels.
	task automatic run_frames(input logic [APB_DATA_W-1:0] width,
			input logic [APB_DATA_W-1:0] height, input int unsigned count,
			input pixel_style_t style);
		settle();
		steady_in = ($urandom_range(0, 3) == 0);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_IMAGE_HEIGHT, height);
		push_pixels(count, style);
	endtask

	// Result side: check each beat at the edge it is taken, then pick the next idle.
	initial begin
		int unsigned beats;
		int unsigned stall_left;
		result_t     got;
		beats      = 0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.energy      = energy_value;
				got.row         = row_index;
				got.col         = column_index;
				got.last_of_run = last_of_run;
				got.frame_done  = frame_done;
				sb.check_beat(got);
				beats++;
				if (beats % 150 == 0) steady_out = ($urandom_range(0, 2) == 0);
				// Once, hold off long enough for the block to back up to its input.
				if (beats == HOLD_AT_BEAT) stall_left = LONG_HOLD;
				else stall_left = next_gap(steady_out);
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned pushed, w, h, frames;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 checkerboard: corners, edges, a full interior pixel, peak energy.
		run_frames(3, 3, 9, PIX_CHECKER);
		// Width 0 used as 1, height 0 used as 1: every pixel is its own frame.
		run_frames(0, 0, 2, PIX_RANDOM);
		// Tallest height, then drop it to the value of the row counter mid-frame: the row in
		// flight becomes the last row and the counter wraps to a new frame.
		run_frames(2, 32'h0000FFFF, 4, PIX_RANDOM);
		settle();
		write_reg(REG_IMAGE_HEIGHT, 2);
		push_pixels(2, PIX_RANDOM);
		// Shrink the width partway through the first row: the next column lies past
		// the new width and closes the row.
		run_frames(5, 2, 3, PIX_RANDOM);
		settle();
		write_reg(REG_IMAGE_WIDTH, 2);
		push_pixels(3, PIX_RANDOM);

		// Width register above the limit, clamped; a short single-row frame that a
		// narrower width then closes.
		run_frames(32'h000007FF, 1, 3, PIX_RANDOM);
		settle();
		write_reg(REG_IMAGE_WIDTH, 2);
		push_pixels(1, PIX_RANDOM);

		// Pressure frame: the long result hold starts inside it while pixels keep coming.
		run_frames(8, 8, 64, PIX_RANDOM);

		// Mostly small random frames.
		pushed = 0;
		while (pushed < 50) begin
			w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
			frames = (w > 8) ? 1 : $urandom_range(1, 2);
			run_frames(w, h, w * h * frames, PIX_RANDOM);
			pushed += w * h * frames;
		end

		settle();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/pge_pkg.sv
rtl/pge_fifo.sv
rtl/pge_front.sv
rtl/pge_back.sv
rtl/pixel_gradient_energy_map.sv
dv/pixel_gradient_energy_map_test.sv
